// File: rtl/core/sds_pkg.sv
// Shared types and constants of the stream delimiter splitter.
`default_nettype none
package sds_pkg;

  localparam int DATA_W   = 8;
  localparam int LEN_W    = 4;
  localparam int DBYTES_W = 64;
  localparam int CNT_W    = 3;
  localparam int ENDS_W   = 2;
  localparam int IDX_W    = 2;

  typedef logic [DATA_W-1:0]   byte_t;
  typedef logic [LEN_W-1:0]    len_t;
  typedef logic [DBYTES_W-1:0] dbytes_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [ENDS_W-1:0]   ends_t;
  typedef logic [IDX_W-1:0]    reg_idx_t;

  // Configuration register indexes.
  localparam reg_idx_t REG_DELIM_LEN   = 2'd0;
  localparam reg_idx_t REG_DELIM_BYTES = 2'd1;
  localparam reg_idx_t REG_KEEP_EMPTY  = 2'd2;

  localparam len_t    DELIM_LEN_RST   = 4'd1;
  localparam dbytes_t DELIM_BYTES_RST = 64'd44;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_REL,
    ST_BYTE,
    ST_END
  } state_t;

  // Result of the shared byte select and compare unit.
  typedef struct packed {
    byte_t sel;
    logic  hit;
  } cmp_res_t;

endpackage
`default_nettype wire

// File: rtl/core/sds_in_if.sv
// Input channel of the stream delimiter splitter: valid/ready plus one item.
`default_nettype none
interface sds_in_if;
  import sds_pkg::*;

  logic  valid;
  logic  ready;
  logic  has_byte;
  byte_t data_byte;
  logic  end_of_string;

  modport source (output valid, output has_byte, output data_byte,
                  output end_of_string, input ready);
  modport sink   (input valid, input has_byte, input data_byte,
                  input end_of_string, output ready);
endinterface
`default_nettype wire

// File: rtl/core/sds_out_if.sv
// Result channel of the stream delimiter splitter: valid/ready plus one result.
`default_nettype none
interface sds_out_if;
  import sds_pkg::*;

  logic  valid;
  logic  ready;
  byte_t out_byte;
  logic  byte_valid;
  logic  part_end;
  logic  last;

  modport source (output valid, output out_byte, output byte_valid,
                  output part_end, output last, input ready);
  modport sink   (input valid, input out_byte, input byte_valid,
                  input part_end, input last, output ready);
endinterface
`default_nettype wire

// File: rtl/core/sds_match_unit.sv
// Shared delimiter byte selector and comparator.
`default_nettype none
module sds_match_unit (
  input  sds_pkg::dbytes_t delim_bytes,
  input  sds_pkg::cnt_t    idx,
  input  sds_pkg::byte_t   data_byte,
  output sds_pkg::cmp_res_t res
);
  import sds_pkg::*;

  byte_t sel;

  // Byte idx of the packed delimiter, byte 0 in the low bits.
  assign sel     = delim_bytes[{idx, 3'b000} +: DATA_W];
  assign res.sel = sel;
  assign res.hit = (sel == data_byte);

endmodule
`default_nettype wire

// File: rtl/core/stream_delimiter_splitter_top.sv
// Top level of the stream delimiter splitter: sequencer, state and result register.
// An item is taken in ST_IDLE, evaluated in ST_CMP and then emits its N results
// (0 to 9) one per cycle while the output can load, and the next item waits for ST_IDLE.
// The item is registered on acceptance and planned in ST_CMP; results then load the output register.
// The rate is set by the single compare unit and the one-result-per-cycle sequencer.
// Reset (synchronous, rst_n low) restores delim_len 1, delimiter ',' and keep_empty 0,
// clears the match count, the part flag and the output valid flag.
`default_nettype none
module stream_delimiter_splitter_top #(
  parameter int DELIM_MAX = 8
) (
  input  wire                 clk,
  input  wire                 rst_n,
  sds_in_if.sink              in_bus,
  sds_out_if.source           out_bus,
  input  wire                 cfg_we,
  input  sds_pkg::reg_idx_t   cfg_index,
  input  sds_pkg::dbytes_t    cfg_data
);
  import sds_pkg::*;

  // Configuration registers.
  len_t    delim_len_r;
  dbytes_t delim_bytes_r;
  logic    keep_empty_r;

  // Block state kept between items.
  cnt_t    match_count_r, match_count_nxt;
  logic    part_has_r, part_has_nxt;

  // Sequencer and the item being worked on.
  state_t  state_r, state_nxt;
  logic    has_r, eos_r;
  byte_t   byte_r;
  cnt_t    rel_cnt_r, rel_cnt_nxt;
  cnt_t    rel_idx_r, rel_idx_nxt;
  logic    emit_b_r, emit_b_nxt;
  ends_t   end_cnt_r, end_cnt_nxt;

  // Output register.
  logic    out_valid_r;
  byte_t   out_byte_r;
  logic    byte_valid_r, part_end_r, last_r;
  logic    load;
  byte_t   ld_byte;
  logic    ld_bvalid, ld_pend, ld_last;

  // Evaluation of the held item.
  len_t     len;
  cnt_t     mc0;
  len_t     mc_inc;
  cnt_t     unit_idx;
  cmp_res_t cmp;
  logic     in_acc, can_load;
  cnt_t     r1, mc1;
  logic     phb1, end_a, end_b;

  assign in_acc   = in_bus.valid && in_bus.ready;
  assign can_load = !out_valid_r || out_bus.ready;

  // A length above DELIM_MAX behaves as DELIM_MAX.
  assign len = (delim_len_r > LEN_W'(DELIM_MAX)) ? LEN_W'(DELIM_MAX) : delim_len_r;
  // A stale count (zero length or count not below length) restarts the match.
  assign mc0 = ((len == '0) || ({1'b0, match_count_r} >= len)) ? '0 : match_count_r;
  assign mc_inc = {1'b0, mc0} + LEN_W'(1);

  // The one compare unit serves the match test and the release of held bytes.
  assign unit_idx = (state_r == ST_REL) ? rel_idx_r : mc0;

  sds_match_unit u_match (
    .delim_bytes (delim_bytes_r),
    .idx         (unit_idx),
    .data_byte   (byte_r),
    .res         (cmp)
  );

  // Plan of the item: released delimiter bytes, then the item's own byte, then
  // up to two part ends (one from a full match, one from the end of the string).
  always_comb begin
    r1    = '0;
    mc1   = mc0;
    phb1  = part_has_r;
    end_a = 1'b0;
    end_b = 1'b0;
    emit_b_nxt = 1'b0;
    if (has_r) begin
      if (len == '0) begin
        emit_b_nxt = 1'b1;
        end_a      = 1'b1;
        phb1       = 1'b0;
        mc1        = '0;
      end else if (cmp.hit) begin
        if (mc_inc >= len) begin
          mc1   = '0;
          end_a = part_has_r || keep_empty_r;
          phb1  = 1'b0;
        end else begin
          mc1 = mc_inc[CNT_W-1:0];
        end
      end else begin
        r1         = mc0;
        emit_b_nxt = 1'b1;
        phb1       = 1'b1;
        mc1        = '0;
      end
    end
    if (eos_r && (len != '0)) begin
      end_b = phb1 || (mc1 != '0) || keep_empty_r;
    end
  end

  // Sequencer: next state, plan registers and result to load.
  always_comb begin
    state_nxt       = state_r;
    match_count_nxt = match_count_r;
    part_has_nxt    = part_has_r;
    rel_cnt_nxt     = rel_cnt_r;
    rel_idx_nxt     = rel_idx_r;
    end_cnt_nxt     = end_cnt_r;
    load            = 1'b0;
    ld_byte         = '0;
    ld_bvalid       = 1'b0;
    ld_pend         = 1'b0;
    ld_last         = 1'b0;
    in_bus.ready    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_bus.ready = 1'b1;
        if (in_acc) begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        // At most one of the two releases is non-empty: a mismatch leaves no count.
        rel_cnt_nxt = eos_r && (len != '0) ? (r1 | mc1) : r1;
        rel_idx_nxt = '0;
        end_cnt_nxt = ENDS_W'(end_a) + ENDS_W'(end_b);
        if (eos_r) begin
          match_count_nxt = '0;
          part_has_nxt    = 1'b0;
        end else begin
          match_count_nxt = mc1;
          part_has_nxt    = phb1;
        end
        if (rel_cnt_nxt != '0) begin
          state_nxt = ST_REL;
        end else if (emit_b_nxt) begin
          state_nxt = ST_BYTE;
        end else if (end_cnt_nxt != '0) begin
          state_nxt = ST_END;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_REL: begin
        if (can_load) begin
          load      = 1'b1;
          ld_byte   = cmp.sel;
          ld_bvalid = 1'b1;
          rel_idx_nxt = rel_idx_r + CNT_W'(1);
          if (rel_idx_nxt == rel_cnt_r) begin
            ld_last = !emit_b_r && (end_cnt_r == '0);
            if (emit_b_r) begin
              state_nxt = ST_BYTE;
            end else if (end_cnt_r != '0) begin
              state_nxt = ST_END;
            end else begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      ST_BYTE: begin
        if (can_load) begin
          load      = 1'b1;
          ld_byte   = byte_r;
          ld_bvalid = 1'b1;
          ld_last   = (end_cnt_r == '0);
          state_nxt = (end_cnt_r == '0) ? ST_IDLE : ST_END;
        end
      end
      ST_END: begin
        if (can_load) begin
          load        = 1'b1;
          ld_pend     = 1'b1;
          ld_last     = (end_cnt_r == ENDS_W'(1));
          end_cnt_nxt = end_cnt_r - ENDS_W'(1);
          if (end_cnt_r == ENDS_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register, configuration and block state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      delim_len_r   <= DELIM_LEN_RST;
      delim_bytes_r <= DELIM_BYTES_RST;
      keep_empty_r  <= 1'b0;
      match_count_r <= '0;
      part_has_r    <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      part_has_r    <= part_has_nxt;
      // A write to the length or the delimiter drops any held bytes.
      if (cfg_we && ((cfg_index == REG_DELIM_LEN) || (cfg_index == REG_DELIM_BYTES))) begin
        match_count_r <= '0;
      end else begin
        match_count_r <= match_count_nxt;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_DELIM_LEN: begin
            delim_len_r   <= cfg_data[LEN_W-1:0];
          end
          REG_DELIM_BYTES: begin
            delim_bytes_r <= cfg_data;
          end
          REG_KEEP_EMPTY: begin
            keep_empty_r <= cfg_data[0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Item and plan registers carry payload only.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      has_r  <= in_bus.has_byte;
      byte_r <= in_bus.data_byte;
      eos_r  <= in_bus.end_of_string;
    end
    rel_cnt_r <= rel_cnt_nxt;
    rel_idx_r <= rel_idx_nxt;
    end_cnt_r <= end_cnt_nxt;
    if (state_r == ST_CMP) begin
      emit_b_r <= emit_b_nxt;
    end
  end

  // Output register: holds a result until the sink takes the beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r   <= ld_byte;
      byte_valid_r <= ld_bvalid;
      part_end_r   <= ld_pend;
      last_r       <= ld_last;
    end
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.out_byte   = out_byte_r;
  assign out_bus.byte_valid = byte_valid_r;
  assign out_bus.part_end   = part_end_r;
  assign out_bus.last       = last_r;

endmodule
`default_nettype wire

// File: tb/tb_stream_delimiter_splitter_top.sv
// Testbench of the stream delimiter splitter: random strings checked against a built-in splitter.
`timescale 1ns / 1ps
module tb_stream_delimiter_splitter_top;
  import sds_pkg::*;

  localparam int DELIM_MAX = 8;
  // The longest run of cycles with no beat on either side before the run is abandoned.
  // The long receiver hold-off is the slowest correct stretch, so this is several times it.
  localparam int WATCHDOG  = 2000;
  localparam int LONG_HOLD = 300;
  // An item that yields no result can still be inside the block when the last result
  // has left; it is gone once its ST_CMP state has passed, so this margin covers it comfortably.
  localparam int SETTLE    = 8;

  typedef struct {
    logic  has_byte;
    byte_t data_byte;
    logic  eos;
  } item_t;

  typedef struct {
    byte_t data;
    logic  has_data;
    logic  closes;
    logic  last;
  } piece_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     cfg_we;
  reg_idx_t cfg_index;
  dbytes_t  cfg_data;

  sds_in_if  in_ch();
  sds_out_if out_ch();

  stream_delimiter_splitter_top #(.DELIM_MAX(DELIM_MAX)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_ch),
    .out_bus   (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Our own copy of the configuration and of the splitting state. It is updated when
  // an item is accepted, so it always describes the block as the next item will see it.
  len_t    m_len   = DELIM_LEN_RST;
  dbytes_t m_delim = DELIM_BYTES_RST;
  logic    m_keep  = 1'b0;
  int      held_cnt  = 0;
  logic    part_open = 1'b0;

  item_t  items_to_send[$];
  piece_t pieces_due[$];

  int n_queued = 0;
  int n_items = 0;
  int n_results = 0;
  int n_part_ends = 0;
  int n_settings = 0;
  int errors = 0;

  // Handshake bookkeeping shared between the clocked processes.
  logic in_took = 1'b0;
  logic out_took = 1'b0;
  int   in_gap = 0;
  int   out_stall = 0;
  int   in_idle_max = 3;
  int   out_idle_max = 3;
  int   hold_left = 0;
  int   holds_asked = 0;
  int   holds_done = 0;

  // A delimiter length beyond the block's maximum behaves as the maximum.
  function automatic int active_len();
    return (int'(m_len) > DELIM_MAX) ? DELIM_MAX : int'(m_len);
  endfunction

  function automatic byte_t delim_byte(int i);
    return m_delim[8*i +: 8];
  endfunction

  function automatic void due_piece(byte_t d, logic bv, logic pe);
    piece_t p;
    p.data     = bv ? d : '0;
    p.has_data = bv;
    p.closes   = pe;
    p.last     = 1'b0;
    pieces_due.push_back(p);
  endfunction

  // Held bytes are known to equal the first bytes of the delimiter, so only their
  // number is kept and the bytes themselves are read back from the delimiter.
  function automatic void flush_held();
    for (int i = 0; i < held_cnt; i++) begin
      due_piece(delim_byte(i), 1'b1, 1'b0);
      part_open = 1'b1;
    end
    held_cnt = 0;
  endfunction

  // Works out every result that one accepted item causes and queues them in order.
  function automatic void split_item(item_t it);
    int len;
    int first;
    len   = active_len();
    first = pieces_due.size();
    if (len == 0 || held_cnt >= len) held_cnt = 0;
    if (it.has_byte) begin
      if (len == 0) begin
        // Without a delimiter every byte is a part of its own.
        due_piece(it.data_byte, 1'b1, 1'b0);
        due_piece('0, 1'b0, 1'b1);
        part_open = 1'b0;
      end else if (it.data_byte == delim_byte(held_cnt)) begin
        held_cnt++;
        if (held_cnt >= len) begin
          held_cnt = 0;
          if (part_open || m_keep) due_piece('0, 1'b0, 1'b1);
          part_open = 1'b0;
        end
      end else begin
        // A mismatch releases what was held plus this byte; the byte is not
        // tried again as the start of a fresh match.
        flush_held();
        due_piece(it.data_byte, 1'b1, 1'b0);
        part_open = 1'b1;
      end
    end
    if (it.eos) begin
      if (len != 0) begin
        flush_held();
        if (part_open || m_keep) due_piece('0, 1'b0, 1'b1);
      end
      held_cnt  = 0;
      part_open = 1'b0;
    end
    if (pieces_due.size() > first) pieces_due[$].last = 1'b1;
  endfunction

  function automatic void push_item(logic has, byte_t d, logic eos);
    item_t it;
    it.has_byte  = has;
    it.data_byte = d;
    it.eos       = eos;
    items_to_send.push_back(it);
    n_queued++;
  endfunction

  // One well-formed string with random content: whole delimiters, broken-off
  // delimiter prefixes, bytes taken from the delimiter and plain random bytes.
  function automatic void queue_string();
    int len;
    int toks;
    int kind;
    int cut;
    len  = active_len();
    toks = $urandom_range(1, 10);
    for (int t = 0; t < toks; t++) begin
      kind = $urandom_range(0, 9);
      if (len > 0 && kind <= 2) begin
        for (int j = 0; j < len; j++) push_item(1'b1, delim_byte(j), 1'b0);
      end else if (len > 0 && kind <= 4) begin
        cut = $urandom_range(0, len - 1);
        for (int j = 0; j < cut; j++) push_item(1'b1, delim_byte(j), 1'b0);
        push_item(1'b1, byte_t'($urandom), 1'b0);
      end else if (kind == 5) begin
        push_item(1'b0, byte_t'($urandom), 1'b0);
      end else if (len > 0 && kind <= 7) begin
        push_item(1'b1, delim_byte($urandom_range(0, len - 1)), 1'b0);
      end else begin
        push_item(1'b1, byte_t'($urandom), 1'b0);
      end
    end
    // Now and then the string is left open, so that it may run into the next
    // delimiter setting with bytes still held.
    case ($urandom_range(0, 7))
      0: ;
      1, 2: push_item(1'b0, byte_t'($urandom), 1'b1);
      default: push_item(1'b1, byte_t'($urandom), 1'b1);
    endcase
  endfunction

  function automatic dbytes_t pick_delim();
    dbytes_t d;
    d = '0;
    case ($urandom_range(0, 3))
      0: d = {$urandom, $urandom};
      1: begin
        for (int i = 0; i < 8; i++) d[8*i +: 8] = $urandom_range(0, 1) ? 8'h61 : 8'h62;
      end
      2: d = {8{8'h61}};
      default: d = $urandom_range(0, 1) ? '1 : '0;
    endcase
    return d;
  endfunction

  // The input side. Acceptance is seen at the rising edge, new items go out at the
  // falling edge, and after each beat the sender waits a drawn number of cycles.
  always @(posedge clk) begin : in_accept
    item_t it;
    in_took = rst_n && in_ch.valid && in_ch.ready;
    if (in_took) begin
      it.has_byte  = in_ch.has_byte;
      it.data_byte = in_ch.data_byte;
      it.eos       = in_ch.end_of_string;
      split_item(it);
      n_items++;
    end
  end

  always @(negedge clk) begin : in_drive
    logic  next_valid;
    item_t nx;
    next_valid = in_ch.valid && !in_took;
    if (!rst_n) begin
      next_valid = 1'b0;
    end else if (!next_valid) begin
      if (in_gap > 0) begin
        in_gap--;
      end else if (items_to_send.size() > 0) begin
        nx = items_to_send.pop_front();
        in_ch.has_byte      <= nx.has_byte;
        in_ch.data_byte     <= nx.data_byte;
        in_ch.end_of_string <= nx.eos;
        next_valid = 1'b1;
        in_gap = $urandom_range(0, in_idle_max);
      end
    end
    in_ch.valid <= next_valid;
  end

  // The result side. Each beat is compared, field by field, with the oldest
  // expectation; only the first ten mismatches are printed in full.
  always @(posedge clk) begin : out_check
    piece_t want;
    out_took = rst_n && out_ch.valid && out_ch.ready;
    if (out_took) begin
      n_results++;
      if (out_ch.part_end === 1'b1) n_part_ends++;
      if (pieces_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result %0d: byte %02h valid %b end %b last %b", n_results,
                   out_ch.out_byte, out_ch.byte_valid, out_ch.part_end, out_ch.last);
      end else begin
        want = pieces_due.pop_front();
        if (out_ch.out_byte !== want.data || out_ch.byte_valid !== want.has_data ||
            out_ch.part_end !== want.closes || out_ch.last !== want.last) begin
          errors++;
          if (errors <= 10)
            $display({"mismatch at result %0d: expected byte %02h valid %b end %b last %b,",
                      " got byte %02h valid %b end %b last %b"}, n_results,
                     want.data, want.has_data, want.closes, want.last,
                     out_ch.out_byte, out_ch.byte_valid, out_ch.part_end, out_ch.last);
        end
      end
    end
  end

  // Ready is dropped for a drawn number of cycles after each beat, and for a long
  // stretch whenever a hold-off has been asked for, so that the block backs up.
  always @(negedge clk) begin : out_drive
    logic next_ready;
    if (out_took) out_stall = $urandom_range(0, out_idle_max);
    if (holds_asked != holds_done) begin
      hold_left = LONG_HOLD;
      holds_done++;
    end
    if (!rst_n) begin
      next_ready = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      next_ready = 1'b0;
    end else if (out_stall > 0) begin
      out_stall--;
      next_ready = 1'b0;
    end else begin
      next_ready = 1'b1;
    end
    out_ch.ready <= next_ready;
  end

  // All three registers are written back to back; the block is idle whenever this runs.
  // Writing the length or the delimiter drops any held bytes, but an open part stays open.
  task automatic set_delimiter(len_t len, dbytes_t dbytes, logic keep);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_DELIM_LEN;
    cfg_data  <= dbytes_t'(len);
    @(negedge clk);
    cfg_index <= REG_DELIM_BYTES;
    cfg_data  <= dbytes;
    @(negedge clk);
    cfg_index <= REG_KEEP_EMPTY;
    cfg_data  <= dbytes_t'(keep);
    @(negedge clk);
    cfg_we <= 1'b0;
    m_len    = len;
    m_delim  = dbytes;
    m_keep   = keep;
    held_cnt = 0;
    n_settings++;
  endtask

  // The sender stops until every queued item is taken and every result has come back.
  task automatic wait_idle();
    do @(posedge clk);
    while (items_to_send.size() != 0 || in_ch.valid || pieces_due.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin : stimulus
    len_t len;
    int   goal;
    in_ch.valid         = 1'b0;
    in_ch.has_byte      = 1'b0;
    in_ch.data_byte     = '0;
    in_ch.end_of_string = 1'b0;
    out_ch.ready        = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = REG_DELIM_LEN;
    cfg_data            = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part with the reset setting, a single comma: an empty item, a byte,
    // a delimiter closing the part, a second delimiter giving a suppressed empty part,
    // an all-ones byte, an end without a byte, and a delimiter arriving with the end.
    push_item(1'b0, 8'h5a, 1'b0);
    push_item(1'b1, 8'h61, 1'b0);
    push_item(1'b1, 8'h2c, 1'b0);
    push_item(1'b1, 8'h2c, 1'b0);
    push_item(1'b1, 8'hff, 1'b0);
    push_item(1'b0, 8'h00, 1'b1);
    push_item(1'b1, 8'h2c, 1'b1);
    wait_idle();

    // Three-byte delimiter with empty parts kept: a mismatch after two held bytes,
    // a full match, a repeated first byte that is not retried, and finally a held
    // byte left behind when the setting changes.
    set_delimiter(4'd3, 64'h0000_0000_00ff_6261, 1'b1);
    push_item(1'b1, 8'h61, 1'b0);
    push_item(1'b1, 8'h62, 1'b0);
    push_item(1'b1, 8'h63, 1'b0);
    push_item(1'b1, 8'h61, 1'b0);
    push_item(1'b1, 8'h62, 1'b0);
    push_item(1'b1, 8'hff, 1'b0);
    push_item(1'b1, 8'h61, 1'b0);
    push_item(1'b1, 8'h61, 1'b0);
    push_item(1'b1, 8'h61, 1'b0);
    wait_idle();

    // Zero length: each byte is a part, and the end of the string closes nothing more.
    set_delimiter(4'd0, '1, 1'b1);
    push_item(1'b1, 8'h78, 1'b1);
    push_item(1'b0, 8'h00, 1'b1);
    wait_idle();

    // Length above the maximum acts as eight all-ones bytes.
    set_delimiter(4'd15, '1, 1'b0);
    repeat (8) push_item(1'b1, 8'hff, 1'b0);
    push_item(1'b1, 8'h00, 1'b1);
    wait_idle();

    // Random part: each phase has its own delimiter setting and its own idling.
    for (int p = 0; p < 10; p++) begin
      case (p)
        0: len = 4'd0;
        1: len = 4'd8;
        2: len = 4'd15;
        3: len = 4'd1;
        default: len = $urandom_range(0, 3) == 0 ? len_t'($urandom_range(0, 15))
                                                 : len_t'($urandom_range(1, 3));
      endcase
      set_delimiter(len, pick_delim(), (p < 2) ? p[0] : 1'($urandom_range(0, 1)));
      case (p % 3)
        0: begin
          in_idle_max  = 0;
          out_idle_max = 19;
        end
        1: begin
          in_idle_max  = 3;
          out_idle_max = 0;
        end
        default: begin
          in_idle_max  = 19;
          out_idle_max = 3;
        end
      endcase
      if (p == 9) begin
        in_idle_max  = 0;
        out_idle_max = 0;
      end
      // One phase starts with the receiver holding off while items keep coming.
      if (p == 4) holds_asked++;
      goal = n_queued + 32;
      while (n_queued < goal) queue_string();
      wait_idle();
    end

    errors += pieces_due.size();
    $display("Covered %0d items and %0d checked results, %0d of them part ends,",
             n_items, n_results, n_part_ends);
    $display("over %0d delimiter settings with and without idling and a long hold-off.",
             n_settings);
    if (errors == 0) begin
      $display("tb_stream_delimiter_splitter_top: done, clean");
    end else begin
      $display("tb_stream_delimiter_splitter_top: done, errors");
    end
    $finish;
  end

  // Counts cycles with no beat on either side and gives up once the limit is reached.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: %0d cycles without a beat", WATCHDOG);
    $display("tb_stream_delimiter_splitter_top: done, errors");
    $finish;
  end

endmodule
